// ===== sv/rllt_pkg.sv =====
package rllt_pkg;

    // field widths
    localparam int LINE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int INDEX_W = 16;

    // largest count one run may hold
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

    // item kinds carried in the input tuser
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_COUNT_FULL = 2'd2,
        ST_PAST_END   = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RECORD,
        S_READ,
        S_ACC,
        S_DONE
    } state_t;

endpackage

// ===== sv/run_length_line_table_top.sv =====
// Run-length table of source line numbers. A record transaction (tuser = 0)
// appends one byte with the given line unless the table or the newest run's
// count is full: a line above the newest run's line, or the first record,
// opens a run; any other line adds one to the newest run's count. A query
// transaction (tuser = 1) returns the line of the byte at the given index.
// One item is handled at a time and every item gives exactly one result. A
// record updates the table in S_RECORD, then passes its result on in S_DONE.
// A query walks the stored runs in turn (S_READ, then S_ACC) until the sum
// passes the index or the runs run out, then passes its result on in S_DONE:
// the runs are read one after another from a table with a registered read,
// and one accumulator adds each count and compares the sum with the index.
// The result sits in an output register, so the next item can be taken while
// it waits; a finished item waits as long as that register is still held by
// the receiver. No clearing pass is needed after reset: only runs below the
// run count are ever read.
module run_length_line_table_top
    import rllt_pkg::*;
#(
    parameter int MAX_RUNS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // line [7:0], index [23:8]
    input  logic        s_axis_tuser,   // mode [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // found_line [7:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    localparam int AW    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RU_W  = $clog2(MAX_RUNS + 1);
    localparam int SUM_W = $clog2(MAX_RUNS * 255 + 1);
    localparam int CMP_W = (SUM_W > INDEX_W) ? SUM_W : INDEX_W;
    localparam int ENT_W = LINE_W + COUNT_W;

    // control state
    state_t                state_reg, state_next;
    logic [RU_W-1:0]       runs_used_reg, runs_used_next;
    logic [LINE_W-1:0]     last_line_reg, last_line_next;
    logic [COUNT_W-1:0]    top_count_reg, top_count_next;
    logic [AW-1:0]         walk_idx_reg, walk_idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  m_valid_reg, m_valid_next;

    // payload state
    logic [LINE_W-1:0]     line_in_reg, line_in_next;
    logic [INDEX_W-1:0]    index_in_reg, index_in_next;
    logic [LINE_W-1:0]     res_found_reg, res_found_next;
    status_t               res_status_reg, res_status_next;
    logic [LINE_W-1:0]     m_found_reg, m_found_next;
    status_t               m_status_reg, m_status_next;

    // run table: line in the upper byte, count in the lower byte
    logic [ENT_W-1:0]      run_mem [MAX_RUNS];
    logic [ENT_W-1:0]      rd_data_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic                  out_free;
    logic                  opens_run;
    logic [RU_W-1:0]       top_idx;
    logic [SUM_W-1:0]      acc_sum;
    logic                  acc_hit;
    logic                  walk_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_found_reg;
    assign m_axis_tuser  = m_status_reg;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign opens_run = (runs_used_reg == '0) || (line_in_reg > last_line_reg);
    assign top_idx   = runs_used_reg - RU_W'(1);

    // shared accumulator and compare
    assign acc_sum   = sum_reg + SUM_W'(rd_data_reg[COUNT_W-1:0]);
    assign acc_hit   = CMP_W'(index_in_reg) < CMP_W'(acc_sum);
    assign walk_last = (RU_W'(walk_idx_reg) + RU_W'(1)) == runs_used_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        runs_used_next  = runs_used_reg;
        last_line_next  = last_line_reg;
        top_count_next  = top_count_reg;
        walk_idx_next   = walk_idx_reg;
        sum_next        = sum_reg;
        m_valid_next    = m_valid_reg;
        line_in_next    = line_in_reg;
        index_in_next   = index_in_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_found_next    = m_found_reg;
        m_status_next   = m_status_reg;
        wr_en           = 1'b0;
        wr_addr         = runs_used_reg[AW-1:0];
        wr_data         = {line_in_reg, COUNT_W'(1)};

        // output register drains independently
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    line_in_next  = s_axis_tdata[LINE_W-1:0];
                    index_in_next = s_axis_tdata[LINE_W +: INDEX_W];
                    res_found_next = '0;
                    if (s_axis_tuser == MODE_RECORD)
                    begin
                        state_next = S_RECORD;
                    end
                    else if (runs_used_reg == '0)
                    begin
                        res_status_next = ST_PAST_END;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        walk_idx_next = '0;
                        sum_next      = '0;
                        state_next    = S_READ;
                    end
                end
            end

            S_RECORD:
            begin
                res_status_next = ST_OK;
                if (opens_run)
                begin
                    if (runs_used_reg == RU_W'(MAX_RUNS))
                    begin
                        res_status_next = ST_TABLE_FULL;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = runs_used_reg[AW-1:0];
                        wr_data        = {line_in_reg, COUNT_W'(1)};
                        runs_used_next = runs_used_reg + RU_W'(1);
                        last_line_next = line_in_reg;
                        top_count_next = COUNT_W'(1);
                    end
                end
                else if (top_count_reg == COUNT_MAX)
                begin
                    res_status_next = ST_COUNT_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_addr        = top_idx[AW-1:0];
                    wr_data        = {last_line_reg, top_count_reg + COUNT_W'(1)};
                    top_count_next = top_count_reg + COUNT_W'(1);
                end
                state_next = S_DONE;
            end

            // table read of the current run is in flight
            S_READ:
            begin
                state_next = S_ACC;
            end

            S_ACC:
            begin
                sum_next = acc_sum;
                if (acc_hit)
                begin
                    res_found_next  = rd_data_reg[ENT_W-1 -: LINE_W];
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else if (walk_last)
                begin
                    res_status_next = ST_PAST_END;
                    state_next      = S_DONE;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + AW'(1);
                    state_next    = S_READ;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            runs_used_reg <= '0;
            last_line_reg <= '0;
            walk_idx_reg  <= '0;
            sum_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            runs_used_reg <= runs_used_next;
            last_line_reg <= last_line_next;
            walk_idx_reg  <= walk_idx_next;
            sum_reg       <= sum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_count_reg  <= top_count_next;
        line_in_reg    <= line_in_next;
        index_in_reg   <= index_in_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_status_reg   <= m_status_next;
    end

    // run table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= run_mem[walk_idx_reg];
    end

endmodule

// ===== sv/rllt_checker.sv =====
module rllt_checker
    import rllt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    // any result that is not ok carries line zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("non-zero line with error status");

    // one item at a time: busy right after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

    // a new result appears only as the block finishes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a pending item");

endmodule

bind run_length_line_table_top rllt_checker u_rllt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
